// ----- hdl/asfdmx_pkg.sv -----
`default_nettype none
package asfdmx_pkg;

  // Largest packet size that the packet position counter can track.
  localparam logic [15:0] MAX_PACKET_BYTES = 16'hFFFF;

  // Reset values of the configuration registers.
  localparam logic [15:0] PACKET_BYTES_RESET  = 16'd4096;
  localparam logic [6:0]  WANTED_STREAM_RESET = 7'd1;

  // Configuration register indexes.
  localparam logic [7:0] REG_PACKET_BYTES  = 8'd0;
  localparam logic [7:0] REG_WANTED_STREAM = 8'd1;

  // Result kinds.
  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_CLOSED    = 2'd1;
  localparam logic [1:0] KIND_MALFORMED = 2'd2;

  // Number of time and duration bytes in the packet header.
  localparam logic [3:0] TIME_BYTES = 4'd6;

  typedef enum logic [4:0] {
    PH_EC     = 5'd0,
    PH_ECSKIP = 5'd1,
    PH_LTF    = 5'd2,
    PH_PROP   = 5'd3,
    PH_PKTLEN = 5'd4,
    PH_SEQ    = 5'd5,
    PH_PAD    = 5'd6,
    PH_TIME   = 5'd7,
    PH_PFLAGS = 5'd8,
    PH_STREAM = 5'd9,
    PH_MON    = 5'd10,
    PH_OFF    = 5'd11,
    PH_REPLEN = 5'd12,
    PH_REPL   = 5'd13,
    PH_PLEN   = 5'd14,
    PH_DATA   = 5'd15,
    PH_SKIP   = 5'd16
  } phase_t;

  // Byte count of a variable-width field from its two-bit length type.
  function automatic logic [3:0] type_width(input logic [1:0] t);
    logic [3:0] w;
    case (t)
      2'd1: w = 4'd1;
      2'd2: w = 4'd2;
      2'd3: w = 4'd4;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/asfdmx_if.sv -----
`default_nettype none
// Byte stream channel.
interface asfdmx_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

// Result channel.
interface asfdmx_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic       object_first;
  logic       object_last;
  modport source (output valid, output kind, output payload_byte, output object_first,
                  output object_last, input ready);
  modport sink (input valid, input kind, input payload_byte, input object_first,
                input object_last, output ready);
endinterface

// Configuration write channel.
interface asfdmx_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/asf_packet_payload_demux_core.sv -----
`default_nettype none
// ASF data packet payload demultiplexer. Bytes of the packet stream enter on
// the stream channel, one request per byte, and the block takes one byte in
// every clock cycle unless the result register is full and not being taken;
// a byte waits in the input register, and its result, if any, is loaded into
// the result register when the byte is processed. The whole parse step for a
// byte (field accumulation, the chain of absent header fields, the payload
// length check against the packet end and the media object bookkeeping) is
// done combinationally between those two registers, and that step sets the
// rate. Each byte gives at most one result: a payload byte of the wanted
// stream (kind 0, with object_first and object_last marking media object
// boundaries), an early close marker when a new object starts while one
// holding data is open (kind 1), or a malformed packet marker (kind 2), after
// which the rest of that packet is skipped. Packets have the fixed size held
// in packet_bytes. There is no clearing pass after reset. Configuration
// writes are always taken and should be made only while no byte is in flight.
module asf_packet_payload_demux_core
  import asfdmx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  asfdmx_stream_if.sink   stream,
  asfdmx_result_if.source result,
  asfdmx_cfg_if.sink      cfg
);

  // Configuration registers.
  logic [15:0] packet_bytes;
  logic [6:0]  wanted_stream;

  // Input register.
  logic        s_valid;
  logic [7:0]  s_byte;
  logic        fire;

  // Parse state.
  phase_t      parse_phase, parse_phase_next;
  logic [15:0] packet_pos, packet_pos_next;
  logic [7:0]  length_flags, length_flags_next;
  logic [7:0]  property_bits, property_bits_next;
  logic [31:0] field_accum, field_accum_next;
  logic [3:0]  field_bytes_left, field_bytes_left_next;
  logic [1:0]  field_idx, field_idx_next;
  logic [5:0]  payloads_left, payloads_left_next;
  logic [1:0]  plen_type, plen_type_next;
  logic [31:0] padding_len, padding_len_next;
  logic [31:0] repl_left, repl_left_next;
  logic [31:0] repl_total, repl_total_next;
  logic [31:0] repl_size, repl_size_next;
  logic [15:0] payload_left, payload_left_next;
  logic [31:0] object_size, object_size_next;
  logic [31:0] object_count, object_count_next;
  logic        object_open, object_open_next;
  logic        object_has_data, object_has_data_next;
  logic        payload_selected, payload_selected_next;
  logic [6:0]  pay_stream, pay_stream_next;
  logic        pay_off_zero, pay_off_zero_next;

  // Result of the current step.
  logic        r_have;
  logic [1:0]  r_kind;
  logic [7:0]  r_byte;
  logic        r_first;
  logic        r_last;

  // Header chain control: each flag means "enter this phase now".
  logic        e_pktlen, e_seq, e_pad;
  logic        e_mon, e_off, e_replen, e_repl, d_repl, e_plen;
  logic        rdy, rdy_multi, nxt;
  logic [31:0] rdy_len;
  logic [16:0] cur_pos;
  logic        overrun;
  logic [15:0] len16;
  logic [3:0]  w;
  logic [31:0] repl_k;

  // Result register.
  logic        o_valid;
  logic [1:0]  o_kind;
  logic [7:0]  o_byte;
  logic        o_first;
  logic        o_last;

  // A byte is processed when the result register is free or being emptied.
  assign fire = s_valid && (!o_valid || result.ready);
  assign stream.ready = !s_valid || fire;
  assign cfg.ready = 1'b1;

  assign result.valid        = o_valid;
  assign result.kind         = o_kind;
  assign result.payload_byte = o_byte;
  assign result.object_first = o_first;
  assign result.object_last  = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_bytes  <= PACKET_BYTES_RESET;
      wanted_stream <= WANTED_STREAM_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_PACKET_BYTES) begin
        packet_bytes <= (cfg.data > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : cfg.data;
      end else if (cfg.index == REG_WANTED_STREAM) begin
        wanted_stream <= cfg.data[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (stream.ready) begin
      s_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      s_byte <= stream.stream_byte;
    end
  end

  // Parse step for the byte in the input register.
  always_comb begin
    parse_phase_next      = parse_phase;
    packet_pos_next       = packet_pos;
    length_flags_next     = length_flags;
    property_bits_next    = property_bits;
    field_accum_next      = field_accum;
    field_bytes_left_next = field_bytes_left;
    field_idx_next        = field_idx;
    payloads_left_next    = payloads_left;
    plen_type_next        = plen_type;
    padding_len_next      = padding_len;
    repl_left_next        = repl_left;
    repl_total_next       = repl_total;
    repl_size_next        = repl_size;
    payload_left_next     = payload_left;
    object_size_next      = object_size;
    object_count_next     = object_count;
    object_open_next      = object_open;
    object_has_data_next  = object_has_data;
    payload_selected_next = payload_selected;
    pay_stream_next       = pay_stream;
    pay_off_zero_next     = pay_off_zero;
    r_have  = 1'b0;
    r_kind  = KIND_DATA;
    r_byte  = 8'd0;
    r_first = 1'b0;
    r_last  = 1'b0;
    e_pktlen  = 1'b0;
    e_seq     = 1'b0;
    e_pad     = 1'b0;
    e_mon     = 1'b0;
    e_off     = 1'b0;
    e_replen  = 1'b0;
    e_repl    = 1'b0;
    d_repl    = 1'b0;
    e_plen    = 1'b0;
    rdy       = 1'b0;
    rdy_multi = 1'b0;
    rdy_len   = 32'd0;
    nxt       = 1'b0;
    cur_pos   = {1'b0, packet_pos} + 17'd1;
    overrun   = 1'b0;
    len16     = 16'd0;
    w         = 4'd0;
    repl_k    = repl_total - repl_left;

    case (parse_phase)
      PH_EC: begin
        if (s_byte[7]) begin
          // An error-correction block of the given length comes first.
          field_bytes_left_next = s_byte[3:0];
          parse_phase_next = (s_byte[3:0] == 4'd0) ? PH_LTF : PH_ECSKIP;
        end else begin
          length_flags_next = s_byte;
          parse_phase_next = PH_PROP;
        end
      end
      PH_ECSKIP: begin
        field_bytes_left_next = field_bytes_left - 4'd1;
        if (field_bytes_left_next == 4'd0) begin
          parse_phase_next = PH_LTF;
        end
      end
      PH_LTF: begin
        length_flags_next = s_byte;
        parse_phase_next = PH_PROP;
      end
      PH_PROP: begin
        property_bits_next = s_byte;
        e_pktlen = 1'b1;
      end
      PH_PKTLEN, PH_SEQ, PH_PAD, PH_MON, PH_OFF, PH_REPLEN, PH_PLEN: begin
        // Little-endian accumulation of a variable-width field.
        field_accum_next = field_accum | (32'(s_byte) << {field_idx, 3'b000});
        field_idx_next = field_idx + 2'd1;
        field_bytes_left_next = field_bytes_left - 4'd1;
        if (field_bytes_left_next == 4'd0) begin
          case (parse_phase)
            PH_PKTLEN: e_seq = 1'b1;
            PH_SEQ: e_pad = 1'b1;
            PH_PAD: begin
              padding_len_next = field_accum_next;
              field_bytes_left_next = TIME_BYTES;
              parse_phase_next = PH_TIME;
            end
            PH_MON: e_off = 1'b1;
            PH_OFF: begin
              pay_off_zero_next = (field_accum_next == 32'd0);
              e_replen = 1'b1;
            end
            PH_REPLEN: begin
              repl_total_next = field_accum_next;
              repl_left_next = field_accum_next;
              repl_size_next = 32'd0;
              e_repl = 1'b1;
            end
            default: begin
              rdy = 1'b1;
              rdy_multi = 1'b1;
              rdy_len = field_accum_next;
            end
          endcase
        end
      end
      PH_TIME: begin
        field_bytes_left_next = field_bytes_left - 4'd1;
        if (field_bytes_left_next == 4'd0) begin
          if (length_flags[0]) begin
            parse_phase_next = PH_PFLAGS;
          end else begin
            payloads_left_next = 6'd1;
            parse_phase_next = PH_STREAM;
          end
        end
      end
      PH_PFLAGS: begin
        payloads_left_next = s_byte[5:0];
        plen_type_next = s_byte[7:6];
        parse_phase_next = (s_byte[5:0] != 6'd0) ? PH_STREAM : PH_SKIP;
      end
      PH_STREAM: begin
        pay_stream_next = s_byte[6:0];
        e_mon = 1'b1;
      end
      PH_REPL: begin
        // Only the first four replicated bytes carry the object size.
        if (repl_k < 32'd4) begin
          repl_size_next = repl_size | (32'(s_byte) << {repl_k[1:0], 3'b000});
        end
        repl_left_next = repl_left - 32'd1;
        if (repl_left_next == 32'd0) begin
          d_repl = 1'b1;
        end
      end
      PH_DATA: begin
        payload_left_next = payload_left - 16'd1;
        if (payload_selected) begin
          r_have  = 1'b1;
          r_kind  = KIND_DATA;
          r_byte  = s_byte;
          r_first = !object_has_data;
          object_has_data_next = 1'b1;
          if (object_count != 32'hFFFF_FFFF) begin
            object_count_next = object_count + 32'd1;
          end
          if (payload_left_next == 16'd0 && object_count_next >= object_size &&
              object_size != 32'd0) begin
            r_last = 1'b1;
            object_open_next = 1'b0;
            object_has_data_next = 1'b0;
          end
        end
        if (payload_left_next == 16'd0) begin
          nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Packet header fields that are absent are passed over in the same cycle.
    if (e_pktlen) begin
      w = type_width(length_flags[6:5]);
      if (w != 4'd0) begin
        parse_phase_next = PH_PKTLEN;
        field_bytes_left_next = w;
        field_accum_next = 32'd0;
        field_idx_next = 2'd0;
      end else begin
        e_seq = 1'b1;
      end
    end
    if (e_seq) begin
      w = type_width(length_flags[2:1]);
      if (w != 4'd0) begin
        parse_phase_next = PH_SEQ;
        field_bytes_left_next = w;
        field_accum_next = 32'd0;
        field_idx_next = 2'd0;
      end else begin
        e_pad = 1'b1;
      end
    end
    if (e_pad) begin
      w = type_width(length_flags[4:3]);
      if (w != 4'd0) begin
        parse_phase_next = PH_PAD;
        field_bytes_left_next = w;
        field_accum_next = 32'd0;
        field_idx_next = 2'd0;
      end else begin
        padding_len_next = 32'd0;
        field_bytes_left_next = TIME_BYTES;
        parse_phase_next = PH_TIME;
      end
    end

    // Payload header fields, likewise.
    if (e_mon) begin
      w = type_width(property_bits[5:4]);
      if (w != 4'd0) begin
        parse_phase_next = PH_MON;
        field_bytes_left_next = w;
        field_accum_next = 32'd0;
        field_idx_next = 2'd0;
      end else begin
        e_off = 1'b1;
      end
    end
    if (e_off) begin
      w = type_width(property_bits[3:2]);
      if (w != 4'd0) begin
        parse_phase_next = PH_OFF;
        field_bytes_left_next = w;
        field_accum_next = 32'd0;
        field_idx_next = 2'd0;
      end else begin
        pay_off_zero_next = 1'b1;
        e_replen = 1'b1;
      end
    end
    if (e_replen) begin
      w = type_width(property_bits[1:0]);
      if (w != 4'd0) begin
        parse_phase_next = PH_REPLEN;
        field_bytes_left_next = w;
        field_accum_next = 32'd0;
        field_idx_next = 2'd0;
      end else begin
        repl_total_next = 32'd0;
        repl_left_next = 32'd0;
        repl_size_next = 32'd0;
        e_repl = 1'b1;
      end
    end
    if (e_repl) begin
      if (repl_left_next != 32'd0) begin
        parse_phase_next = PH_REPL;
      end else begin
        d_repl = 1'b1;
      end
    end
    if (d_repl) begin
      if (repl_total_next < 32'd8) begin
        repl_size_next = 32'd0;
      end
      if (length_flags[0]) begin
        e_plen = 1'b1;
      end else begin
        rdy = 1'b1;
      end
    end
    if (e_plen) begin
      w = type_width(plen_type_next);
      if (w != 4'd0) begin
        parse_phase_next = PH_PLEN;
        field_bytes_left_next = w;
        field_accum_next = 32'd0;
        field_idx_next = 2'd0;
      end else begin
        rdy = 1'b1;
        rdy_multi = 1'b1;
      end
    end

    // Payload header complete: check the length against the packet end and
    // open a media object where the payload starts one.
    if (rdy) begin
      if (rdy_multi) begin
        overrun = ({1'b0, rdy_len} + 33'(cur_pos)) > 33'(packet_bytes);
        len16 = rdy_len[15:0];
      end else begin
        overrun = ({1'b0, padding_len_next} + 33'(cur_pos)) > 33'(packet_bytes);
        len16 = packet_bytes - padding_len_next[15:0] - cur_pos[15:0];
      end
      if (overrun) begin
        r_have = 1'b1;
        r_kind = KIND_MALFORMED;
        parse_phase_next = PH_SKIP;
      end else begin
        payload_left_next = len16;
        payload_selected_next = (pay_stream_next == wanted_stream) &&
                                (repl_total_next != 32'd1);
        if (payload_selected_next) begin
          if (pay_off_zero_next) begin
            if (object_open && object_has_data) begin
              r_have = 1'b1;
              r_kind = KIND_CLOSED;
            end
            object_size_next = (repl_size_next != 32'd0) ? repl_size_next : 32'(len16);
            object_count_next = 32'd0;
            object_open_next = 1'b1;
            object_has_data_next = 1'b0;
          end else if (!object_open) begin
            // A fragment with no open object is an orphan.
            payload_selected_next = 1'b0;
          end
        end
        if (len16 == 16'd0) begin
          nxt = 1'b1;
        end else begin
          parse_phase_next = PH_DATA;
        end
      end
    end

    if (nxt) begin
      if (payloads_left_next != 6'd0) begin
        payloads_left_next = payloads_left_next - 6'd1;
      end
      parse_phase_next = (payloads_left_next != 6'd0) ? PH_STREAM : PH_SKIP;
    end

    // Packet boundary. A payload header cut short by the packet end is malformed.
    packet_pos_next = packet_pos + 16'd1;
    if (packet_pos_next == 16'd0 || packet_pos_next >= packet_bytes) begin
      if (!r_have && (parse_phase_next == PH_MON || parse_phase_next == PH_OFF ||
                      parse_phase_next == PH_REPLEN || parse_phase_next == PH_REPL ||
                      parse_phase_next == PH_PLEN)) begin
        r_have = 1'b1;
        r_kind = KIND_MALFORMED;
      end
      packet_pos_next = 16'd0;
      parse_phase_next = PH_EC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_EC;
      packet_pos       <= 16'd0;
      length_flags     <= 8'd0;
      property_bits    <= 8'd0;
      field_accum      <= 32'd0;
      field_bytes_left <= 4'd0;
      field_idx        <= 2'd0;
      payloads_left    <= 6'd0;
      plen_type        <= 2'd0;
      padding_len      <= 32'd0;
      repl_left        <= 32'd0;
      repl_total       <= 32'd0;
      repl_size        <= 32'd0;
      payload_left     <= 16'd0;
      object_size      <= 32'd0;
      object_count     <= 32'd0;
      object_open      <= 1'b0;
      object_has_data  <= 1'b0;
      payload_selected <= 1'b0;
      pay_stream       <= 7'd0;
      pay_off_zero     <= 1'b0;
    end else if (fire) begin
      parse_phase      <= parse_phase_next;
      packet_pos       <= packet_pos_next;
      length_flags     <= length_flags_next;
      property_bits    <= property_bits_next;
      field_accum      <= field_accum_next;
      field_bytes_left <= field_bytes_left_next;
      field_idx        <= field_idx_next;
      payloads_left    <= payloads_left_next;
      plen_type        <= plen_type_next;
      padding_len      <= padding_len_next;
      repl_left        <= repl_left_next;
      repl_total       <= repl_total_next;
      repl_size        <= repl_size_next;
      payload_left     <= payload_left_next;
      object_size      <= object_size_next;
      object_count     <= object_count_next;
      object_open      <= object_open_next;
      object_has_data  <= object_has_data_next;
      payload_selected <= payload_selected_next;
      pay_stream       <= pay_stream_next;
      pay_off_zero     <= pay_off_zero_next;
    end
  end

  // Result register: loaded by every processed byte, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fire) begin
      o_valid <= r_have;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_kind  <= r_kind;
      o_byte  <= r_byte;
      o_first <= r_first;
      o_last  <= r_last;
    end
  end

  // A new packet always starts at position zero.
  a_ec_at_start: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_EC |-> packet_pos == 16'd0)
    else $error("packet header phase away from packet start");

  // The data phase is only held while payload bytes remain.
  a_data_left: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_DATA |-> payload_left != 16'd0)
    else $error("data phase with no payload bytes left");

  // Skipping error-correction bytes always has bytes to skip.
  a_ecskip_left: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_ECSKIP |-> field_bytes_left != 4'd0)
    else $error("error-correction skip with nothing to skip");

  // Data is only ever counted into an open object.
  a_data_open: assert property (@(posedge clk) disable iff (rst)
    object_has_data |-> object_open)
    else $error("object holds data but is not open");

  // Markers carry no object boundary flags.
  a_marker_flags: assert property (@(posedge clk) disable iff (rst)
    (fire && r_have && r_kind != KIND_DATA) |=> (!o_first && !o_last && o_valid))
    else $error("marker result with object flags set");

endmodule
`default_nettype wire

// ----- test/asfdmx_scoreboard.sv -----
`timescale 1ns / 100ps
module asfdmx_scoreboard
  import asfdmx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  asfdmx_stream_if  stream,
  asfdmx_result_if  result,
  asfdmx_cfg_if     cfg,
  output int        fail_count,
  output int        outstanding
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       first;
    logic       last;
  } demux_out_t;

  demux_out_t pending_outputs[$];

  // Register copies.
  logic [15:0] pkt_size;
  logic [6:0]  sel_stream;

  // Parser and object state.
  logic [15:0] pos;
  phase_t      phase;
  logic [7:0]  lt_flags;
  logic [7:0]  prop_flags;
  logic [31:0] accum;
  logic [31:0] bytes_left;
  int          shift_amt;
  logic [5:0]  pay_count;
  logic [31:0] pad_len;
  logic [31:0] repl_left;
  logic [31:0] repl_total;
  logic [31:0] repl_size;
  logic [31:0] pay_left;
  logic [31:0] obj_limit;
  logic [31:0] obj_count;
  logic [6:0]  pay_sid;
  logic [1:0]  len_code;
  logic        obj_open;
  logic        obj_data;
  logic        pay_sel;
  logic        zero_offset;

  logic        got;
  demux_out_t  got_item;

  function automatic void note(logic [1:0] k, logic [7:0] d, logic f, logic l);
    got = 1'b1;
    got_item = '{k, d, f, l};
  endfunction

  function automatic int field_len(logic [1:0] code);
    case (code)
      2'd1: return 1;
      2'd2: return 2;
      2'd3: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic bit sized_field(phase_t p);
    return p inside {PH_PKTLEN, PH_SEQ, PH_PAD, PH_MON, PH_OFF, PH_REPLEN, PH_PLEN};
  endfunction

  function automatic logic [1:0] size_code(phase_t p);
    case (p)
      PH_PKTLEN: return lt_flags[6:5];
      PH_SEQ:    return lt_flags[2:1];
      PH_PAD:    return lt_flags[4:3];
      PH_MON:    return prop_flags[5:4];
      PH_OFF:    return prop_flags[3:2];
      PH_REPLEN: return prop_flags[1:0];
      default:   return len_code;
    endcase
  endfunction

  function automatic phase_t next_payload_phase();
    if (pay_count != 6'd0) pay_count--;
    return (pay_count != 6'd0) ? PH_STREAM : PH_SKIP;
  endfunction

  // The payload header is complete: check it against the packet end and do the
  // media object bookkeeping.
  function automatic phase_t open_payload(bit multi, logic [31:0] len);
    logic [33:0] here;
    here = 34'(pos) + 34'd1;
    if (multi) begin
      if (here + 34'(len) > 34'(pkt_size)) begin
        note(KIND_MALFORMED, 8'd0, 1'b0, 1'b0);
        return PH_SKIP;
      end
    end else begin
      if (34'(pad_len) + here > 34'(pkt_size)) begin
        note(KIND_MALFORMED, 8'd0, 1'b0, 1'b0);
        return PH_SKIP;
      end
      len = 32'(34'(pkt_size) - 34'(pad_len) - here);
    end
    pay_left = len;
    pay_sel = (pay_sid == sel_stream) && (repl_total != 32'd1);
    if (pay_sel) begin
      if (zero_offset) begin
        if (obj_open && obj_data) note(KIND_CLOSED, 8'd0, 1'b0, 1'b0);
        obj_limit = (repl_size != 32'd0) ? repl_size : len;
        obj_count = 32'd0;
        obj_open = 1'b1;
        obj_data = 1'b0;
      end else if (!obj_open) begin
        pay_sel = 1'b0;
      end
    end
    return (len == 32'd0) ? next_payload_phase() : PH_DATA;
  endfunction

  function automatic phase_t field_done(phase_t p, logic [31:0] v);
    case (p)
      PH_PKTLEN: return PH_SEQ;
      PH_SEQ:    return PH_PAD;
      PH_PAD: begin
        pad_len = v;
        bytes_left = 32'(TIME_BYTES);
        return PH_TIME;
      end
      PH_MON:    return PH_OFF;
      PH_OFF: begin
        zero_offset = (v == 32'd0);
        return PH_REPLEN;
      end
      PH_REPLEN: begin
        repl_total = v;
        repl_left = v;
        repl_size = 32'd0;
        return PH_REPL;
      end
      PH_REPL: begin
        if (repl_total < 32'd8) repl_size = 32'd0;
        return lt_flags[0] ? PH_PLEN : open_payload(1'b0, 32'd0);
      end
      default: return open_payload(1'b1, v);
    endcase
  endfunction

  // Enter a phase and pass straight through every field that is absent.
  function automatic void enter(phase_t p);
    int w;
    while (1) begin
      phase = p;
      if (sized_field(p)) begin
        w = field_len(size_code(p));
        if (w != 0) begin
          bytes_left = 32'(w);
          accum = 32'd0;
          shift_amt = 0;
          return;
        end
        p = field_done(p, 32'd0);
      end else if (p == PH_REPL && repl_left == 32'd0) begin
        p = field_done(p, 32'd0);
      end else if (p == PH_ECSKIP && bytes_left == 32'd0) begin
        p = PH_LTF;
      end else begin
        return;
      end
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [31:0] k;
    logic        first;
    logic        last;
    got = 1'b0;
    case (phase)
      PH_EC: begin
        if (b[7]) begin
          bytes_left = 32'(b[3:0]);
          enter(PH_ECSKIP);
        end else begin
          lt_flags = b;
          enter(PH_PROP);
        end
      end
      PH_ECSKIP: begin
        bytes_left--;
        if (bytes_left == 32'd0) enter(PH_LTF);
      end
      PH_LTF: begin
        lt_flags = b;
        enter(PH_PROP);
      end
      PH_PROP: begin
        prop_flags = b;
        enter(PH_PKTLEN);
      end
      PH_TIME: begin
        bytes_left--;
        if (bytes_left == 32'd0) begin
          if (lt_flags[0]) begin
            enter(PH_PFLAGS);
          end else begin
            pay_count = 6'd1;
            enter(PH_STREAM);
          end
        end
      end
      PH_PFLAGS: begin
        pay_count = b[5:0];
        len_code = b[7:6];
        enter((pay_count != 6'd0) ? PH_STREAM : PH_SKIP);
      end
      PH_STREAM: begin
        pay_sid = b[6:0];
        enter(PH_MON);
      end
      PH_REPL: begin
        k = repl_total - repl_left;
        if (k < 32'd4) repl_size |= {24'd0, b} << (8 * k);
        repl_left--;
        if (repl_left == 32'd0) enter(field_done(PH_REPL, 32'd0));
      end
      PH_DATA: begin
        pay_left--;
        if (pay_sel) begin
          first = !obj_data;
          last = 1'b0;
          obj_data = 1'b1;
          if (obj_count != 32'hFFFF_FFFF) obj_count++;
          if (pay_left == 32'd0 && obj_count >= obj_limit && obj_limit != 32'd0) begin
            last = 1'b1;
            obj_open = 1'b0;
            obj_data = 1'b0;
          end
          note(KIND_DATA, b, first, last);
        end
        if (pay_left == 32'd0) enter(next_payload_phase());
      end
      default: begin
        if (sized_field(phase)) begin
          if (shift_amt < 32) accum |= {24'd0, b} << shift_amt;
          shift_amt += 8;
          bytes_left--;
          if (bytes_left == 32'd0) enter(field_done(phase, accum));
        end
      end
    endcase

    // Packet end; a payload header cut off by it is malformed.
    pos = pos + 16'd1;
    if (pos == 16'd0 || pos >= pkt_size) begin
      if (!got && phase inside {PH_MON, PH_OFF, PH_REPLEN, PH_REPL, PH_PLEN})
        note(KIND_MALFORMED, 8'd0, 1'b0, 1'b0);
      pos = 16'd0;
      phase = PH_EC;
    end
  endfunction

  function automatic void clear_model();
    pkt_size = PACKET_BYTES_RESET;
    sel_stream = WANTED_STREAM_RESET;
    pos = '0;
    phase = PH_EC;
    lt_flags = '0;
    prop_flags = '0;
    accum = '0;
    bytes_left = '0;
    shift_amt = 0;
    pay_count = '0;
    pad_len = '0;
    repl_left = '0;
    repl_total = '0;
    repl_size = '0;
    pay_left = '0;
    obj_limit = '0;
    obj_count = '0;
    pay_sid = '0;
    len_code = '0;
    obj_open = 1'b0;
    obj_data = 1'b0;
    pay_sel = 1'b0;
    zero_offset = 1'b0;
  endfunction

  always @(posedge clk) begin
    demux_out_t seen;
    demux_out_t want;
    if (rst) begin
      clear_model();
      pending_outputs.delete();
      fail_count = 0;
    end else begin
      if (result.valid && result.ready) begin
        seen = '{result.kind, result.payload_byte, result.object_first, result.object_last};
        if (pending_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result kind %0d byte %02h first %0b last %0b",
                     $time, seen.kind, seen.data, seen.first, seen.last);
        end else begin
          want = pending_outputs[0];
          pending_outputs.delete(0);
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch, expected kind %0d byte %02h first %0b last %0b,",
                       $time, want.kind, want.data, want.first, want.last,
                       " got kind %0d byte %02h first %0b last %0b",
                       seen.kind, seen.data, seen.first, seen.last);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_PACKET_BYTES)
          pkt_size = (cfg.data > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : cfg.data;
        else if (cfg.index == REG_WANTED_STREAM)
          sel_stream = cfg.data[6:0];
      end
      if (stream.valid && stream.ready) begin
        parse_byte(stream.stream_byte);
        if (got) pending_outputs.push_back(got_item);
      end
    end
    outstanding <= pending_outputs.size();
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the ASF payload demultiplexer. A scoreboard beside
// the block follows every accepted request on the three channels, predicts the
// results and compares them; this module only builds packets and drives them.
module tb;
  import asfdmx_pkg::*;

  logic clk;
  logic rst;

  asfdmx_stream_if stream_ch();
  asfdmx_result_if result_ch();
  asfdmx_cfg_if    cfg_ch();

  int fail_count;
  int outstanding;

  asf_packet_payload_demux_core DUT (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  asfdmx_scoreboard scoreboard (
    .clk         (clk),
    .rst         (rst),
    .stream      (stream_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Percentage of cycles in which the sender holds back and the receiver
  // stalls.
  int src_idle;
  int snk_idle;

  // Settings the packet builder works with, mirrored from the last writes.
  int          cur_pkt;
  logic [6:0]  cur_sid;

  // Progress of the media object currently being sent on the wanted stream,
  // so that most fragments continue it in order.
  bit          obj_active;
  int          obj_total;
  int          obj_sent;

  logic [7:0] gen_q[$];

  // Opening packet at the largest packet size, wanted stream 127: an error
  // correction block with one skipped byte, a multiple-payload header with
  // every optional length field absent, a one-byte offset and no replicated
  // data (so the object size is the payload length). The first payload is a
  // complete two-byte object carrying 00 and FF, the second opens a
  // five-byte object that the packet size change below cuts short.
  logic [7:0] opening_bytes [20] = '{
    8'h81, 8'hFF, 8'h01, 8'h04,
    8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78,
    8'h42,
    8'hFF, 8'h00, 8'h02, 8'h00, 8'hFF,
    8'h7F, 8'h00, 8'h05, 8'hA5
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hard ceiling on the run in case the block stops responding.
  initial begin
    #5_000_000;
    $display("[asf_packet_payload_demux_core] ERROR");
    $finish;
  end

  // The receiver decides each cycle, at the falling edge, whether it stalls.
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  // Sends one byte as a request, idling at random before it. Returns at the
  // falling edge after the byte was accepted, with valid still high so that a
  // following byte can go out without a gap.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      stream_ch.valid <= 1'b0;
      @(negedge clk);
    end
    stream_ch.valid <= 1'b1;
    stream_ch.stream_byte <= b;
    do @(posedge clk); while (!stream_ch.ready);
    @(negedge clk);
  endtask

  // Stops the stream and waits until every predicted result has come out,
  // then waits on for a byte that produces nothing to leave the pipeline.
  task automatic wait_idle();
    stream_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Both registers are written, back to back, only once the block is idle.
  task automatic configure(input int pkt, input logic [6:0] sid);
    wait_idle();
    write_reg(REG_PACKET_BYTES, 16'(pkt));
    write_reg(REG_WANTED_STREAM, {9'd0, sid});
    cfg_ch.valid <= 1'b0;
    cur_pkt = pkt;
    cur_sid = sid;
  endtask

  function automatic int fld_bytes(logic [1:0] code);
    return (code == 2'd3) ? 4 : int'(code);
  endfunction

  // Little-endian field whose width comes from a two-bit length type.
  function automatic void put_field(logic [1:0] code, logic [31:0] v);
    for (int i = 0; i < fld_bytes(code); i++) gen_q.push_back(v[8*i +: 8]);
  endfunction

  // Appends one payload (header and data) and returns its byte count. In a
  // multiple-payload packet the data length is kept within room, except now
  // and then on purpose to make the length overrun the packet. In a single
  // payload packet the data fills whatever room the header leaves.
  function automatic int add_payload(bit multi, int room, logic [1:0] plc, logic [7:0] pr);
    int          start;
    int          hdr;
    int          dl;
    int          rlen;
    int          pick;
    bit          mine;
    bit          tracked;
    logic [31:0] off;
    logic [31:0] osize;
    start = gen_q.size();
    mine = ($urandom_range(4) != 0);
    tracked = 1'b0;
    off = 32'd0;
    if (mine) begin
      if (obj_active && $urandom_range(5) != 0) begin
        off = 32'(obj_sent);
        tracked = 1'b1;
      end else if (!obj_active && $urandom_range(4) == 0) begin
        // Fragment of an object whose start was never seen.
        off = 32'($urandom_range(1, 200));
      end else begin
        obj_total = $urandom_range(1, 48);
        obj_sent = 0;
        obj_active = 1'b1;
        tracked = 1'b1;
      end
      osize = 32'(obj_total);
    end else begin
      off = $urandom_range(1) ? 32'd0 : 32'($urandom_range(1, 300));
      osize = 32'($urandom_range(1, 64));
    end

    // Replicated data: mostly eight bytes holding the object size, sometimes
    // none, sometimes too short to hold a size, and sometimes the single byte
    // that marks a compressed payload.
    if (pr[1:0] == 2'd0) begin
      rlen = 0;
    end else begin
      pick = $urandom_range(9);
      rlen = (pick == 0) ? 1 : (pick == 1) ? 0 : (pick == 2) ? 4 : 8;
    end
    if (tracked && rlen != 8) obj_active = 1'b0;

    hdr = 1 + fld_bytes(pr[5:4]) + fld_bytes(pr[3:2]) + fld_bytes(pr[1:0]) + rlen;
    if (multi) begin
      hdr += fld_bytes(plc);
      if (plc == 2'd0) begin
        dl = 0;
      end else begin
        dl = $urandom_range(1, 24);
        if (tracked && obj_active && dl > obj_total - obj_sent) dl = obj_total - obj_sent;
        if (dl > room - hdr) dl = room - hdr;
        if ($urandom_range(15) == 0) dl = room - hdr + $urandom_range(1, 9);
        if (dl < 0) dl = 0;
        if (plc == 2'd1 && dl > 255) dl = 255;
      end
    end else begin
      dl = room - hdr;
      if (dl < 0) dl = 0;
    end

    gen_q.push_back({1'($urandom_range(1)), mine ? cur_sid : 7'($urandom_range(127))});
    put_field(pr[5:4], $urandom);
    put_field(pr[3:2], off);
    put_field(pr[1:0], 32'(rlen));
    for (int i = 0; i < rlen; i++)
      gen_q.push_back((i < 4) ? osize[8*i +: 8] : 8'($urandom));
    if (multi) put_field(plc, 32'(dl));
    repeat (dl) gen_q.push_back(8'($urandom));

    if (tracked && obj_active) begin
      obj_sent += dl;
      if (obj_sent >= obj_total) obj_active = 1'b0;
    end
    return gen_q.size() - start;
  endfunction

  // Builds exactly one packet of cur_pkt bytes into gen_q. Most packets are
  // well formed with random header layouts; a few are plain noise, some claim
  // more payloads than they hold, carry too much padding or overrun the end.
  function automatic void build_packet();
    int         n;
    int         room;
    int         np;
    int         idx;
    int         eff_pad;
    logic [7:0] lt;
    logic [7:0] pr;
    logic [7:0] pad;
    logic [1:0] plc;
    gen_q.delete();
    if ($urandom_range(11) == 0) begin
      repeat (cur_pkt) gen_q.push_back(8'($urandom));
      return;
    end

    if ($urandom_range(3) == 0) begin
      n = ($urandom_range(7) == 0) ? 15 : $urandom_range(3);
      gen_q.push_back(8'h80 | 8'($urandom_range(7) << 4) | 8'(n));
      repeat (n) gen_q.push_back(8'($urandom));
    end

    lt = 8'($urandom);
    pr = 8'($urandom);
    if (pr[1:0] == 2'd0 && $urandom_range(3) != 0) pr[1:0] = 2'd1;
    pad = 8'($urandom_range(3));
    if ($urandom_range(11) == 0) pad = 8'($urandom_range(100, 255));
    eff_pad = (lt[4:3] == 2'd0) ? 0 : int'(pad);

    gen_q.push_back(lt);
    gen_q.push_back(pr);
    put_field(lt[6:5], 32'(cur_pkt));
    put_field(lt[2:1], $urandom);
    put_field(lt[4:3], {24'd0, pad});
    repeat (6) gen_q.push_back(8'($urandom));

    if (lt[0]) begin
      plc = ($urandom_range(7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
      idx = gen_q.size();
      gen_q.push_back(8'd0);
      room = cur_pkt - gen_q.size();
      np = 0;
      while (room > 0 && np < 63 && (np == 0 || $urandom_range(3) != 0)) begin
        room -= add_payload(1'b1, room, plc, pr);
        np++;
      end
      n = np;
      if ($urandom_range(9) == 0) n = np + 1;
      if ($urandom_range(19) == 0) n = 0;
      if ($urandom_range(39) == 0) n = 63;
      gen_q[idx] = {plc, 6'(n)};
    end else begin
      room = cur_pkt - gen_q.size() - eff_pad;
      void'(add_payload(1'b0, room, 2'd0, pr));
      repeat (eff_pad) gen_q.push_back(8'($urandom));
    end

    while (gen_q.size() > cur_pkt) void'(gen_q.pop_back());
    while (gen_q.size() < cur_pkt) gen_q.push_back(8'($urandom));
  endfunction

  initial begin
    int pkt;
    int budget;
    int sent;
    logic [6:0] sid;

    rst = 1'b1;
    stream_ch.valid = 1'b0;
    stream_ch.stream_byte = 8'd0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_PACKET_BYTES;
    cfg_ch.data = 16'd0;
    src_idle = 30;
    snk_idle = 50;
    obj_active = 1'b0;
    obj_total = 0;
    obj_sent = 0;
    cur_pkt = int'(PACKET_BYTES_RESET);
    cur_sid = WANTED_STREAM_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The opening packet runs at the largest packet size and
    // the highest stream number.
    configure(int'(MAX_PACKET_BYTES), 7'd127);
    foreach (opening_bytes[i]) push_byte(opening_bytes[i]);

    // Shrinking the packet size in the middle of a packet: the next byte is
    // still a payload byte and then ends the packet at once.
    configure(8, 7'd127);
    push_byte(8'h5A);

    // A packet size of zero makes every byte a packet of its own.
    configure(0, 7'd0);
    push_byte(8'h00);
    push_byte(8'h80);
    push_byte(8'hFF);

    // Random part, in segments with their own settings. The sender and
    // receiver idle patterns swap after two segments and go away after four.
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        src_idle = 50;
        snk_idle = 30;
      end else if (seg == 4) begin
        src_idle = 0;
        snk_idle = 0;
      end
      pkt = (seg == 1) ? 8 : $urandom_range(24, 160);
      sid = (seg == 0) ? 7'd0 : (seg == 3) ? 7'd127 : 7'($urandom_range(127));
      configure(pkt, sid);
      obj_active = 1'b0;
      budget = (pkt == 8) ? 48 : 130;
      sent = 0;
      while (sent < budget) begin
        build_packet();
        foreach (gen_q[i]) push_byte(gen_q[i]);
        sent += gen_q.size();
      end
    end

    wait_idle();
    if (fail_count == 0)
      $display("[asf_packet_payload_demux_core] OK");
    else
      $display("[asf_packet_payload_demux_core] ERROR");
    $finish;
  end

endmodule

// ----- asf_packet_payload_demux_core.f -----
hdl/asfdmx_pkg.sv
hdl/asfdmx_if.sv
hdl/asf_packet_payload_demux_core.sv
test/asfdmx_scoreboard.sv
test/tb.sv
